// ===== sv/drt_pkg.sv =====
// ----------------------------------------------------------------------------
// drt_pkg: shared types and constants for the difficulty retarget block
// Field widths, fixed point constants, register map and reset values.
// ----------------------------------------------------------------------------
package drt_pkg;

  localparam int TIME_W    = 40;
  localparam int DIFF_W    = 32;
  localparam int TARGET_W  = 16;
  localparam int WINREG_W  = 7;
  localparam int FACTOR_W  = 16;
  localparam int FRAC_BITS = 16;
  localparam int RATIO_W   = 24;
  localparam int LO_NUM_W  = 25;
  localparam int LO_W      = 17;

  // 1.0 in Q8.8, and 2^24 for the lower ratio bound 1/max_factor in Q1.16
  localparam logic [FACTOR_W-1:0]  FACTOR_ONE = 16'd256;
  localparam logic [LO_NUM_W-1:0]  LO_NUM     = 25'h100_0000;
  localparam logic [FRAC_BITS-1:0] ROUND_HALF = 16'h8000;

  // register map
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_TARGET     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAX_FACTOR = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MIN_DIFF   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MAX_DIFF   = 3'd4;

  localparam logic [TARGET_W-1:0] TARGET_RST     = 16'd10;
  localparam logic [WINREG_W-1:0] WINDOW_RST     = 7'd10;
  localparam logic [FACTOR_W-1:0] MAX_FACTOR_RST = 16'd1024;
  localparam logic [DIFF_W-1:0]   MIN_DIFF_RST   = 32'd1;
  localparam logic [DIFF_W-1:0]   MAX_DIFF_RST   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [TIME_W-1:0] block_time;
    logic [DIFF_W-1:0] current_difficulty;
  } item_t;

  typedef struct packed {
    logic [DIFF_W-1:0] next_difficulty;
    logic              retargeted;
    logic              span_invalid;
  } result_t;

endpackage

// ===== sv/drt_div.sv =====
// ----------------------------------------------------------------------------
// drt_div: bit-serial restoring divider
// One quotient bit per cycle, dividend shifted in from the top.
// ----------------------------------------------------------------------------
module drt_div #(
  parameter int DVD_W = 39,
  parameter int DVS_W = 40
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] shreg;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DVS_W:0]   trial;
  logic             fits;

  always_comb begin
    trial = {rem, shreg[DVD_W-1]};
    fits  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits collect in the low end as the dividend leaves the top
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
      dvs   <= divisor;
    end else if (busy) begin
      shreg <= {shreg[DVD_W-2:0], fits};
      rem   <= fits ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
    end
  end

  assign quotient = shreg;

endmodule

// ===== sv/difficulty_retarget_top.sv =====
// ----------------------------------------------------------------------------
// difficulty_retarget_top: windowed difficulty retarget
// Each transaction on the item channel appends one block (timestamp and the
// difficulty in force) and yields one result transaction. Timestamps go into
// a ring of WINDOW_MAX+1 entries; every window_size blocks after genesis the
// span back to the block window_size places earlier sets a Q8.16 ratio
// window*target/span, clamped to [1/max_factor, max_factor], applied to the
// difficulty with rounding half up and bounded by min/max_difficulty. A step
// with no retarget goes straight to the done state to raise result_valid, a
// step with a span that is not positive passes the span check first. In a
// retarget step the shared bit-serial divider (DVD_W = $clog2(WINDOW_MAX+1) + 32
// dividend bits) runs twice, once for the lower ratio bound and once for the
// ratio, then a bit-serial multiplier steps through the RATIO_W ratio bits.
// One item is worked on at a time; the next is accepted while a result still
// waits, and a finished result stalls until the output register is free.
// ----------------------------------------------------------------------------
module difficulty_retarget_top #(
  parameter int WINDOW_MAX = 64,
  parameter int TIME_BITS  = 40
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_ready,
  input  drt_pkg::item_t          item,
  output logic                    result_valid,
  input  logic                    result_ready,
  output drt_pkg::result_t        result,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [drt_pkg::ADDR_W-1:0] paddr,
  input  logic [drt_pkg::DATA_W-1:0] pwdata,
  output logic [drt_pkg::DATA_W-1:0] prdata,
  output logic                    pready
);

  import drt_pkg::*;

  localparam int RING_DEPTH = WINDOW_MAX + 1;
  localparam int SLOT_W     = $clog2(RING_DEPTH);
  localparam int SEEN_W     = $clog2(RING_DEPTH + 1);
  localparam int SINCE_W    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int NUM_W      = SLOT_W + TARGET_W;
  localparam int DVD_W      = NUM_W + FRAC_BITS;
  localparam int PROD_W     = DIFF_W + RATIO_W;
  localparam int ROUND_W    = PROD_W + 1 - FRAC_BITS;
  localparam int MCNT_W     = $clog2(RATIO_W + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_LO    = 3'd2;
  localparam logic [2:0] S_RATIO = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_ROUND = 3'd5;
  localparam logic [2:0] S_CLAMP = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  // configuration
  logic [TARGET_W-1:0] target_block_time;
  logic [WINREG_W-1:0] window_size;
  logic [FACTOR_W-1:0] max_factor;
  logic [DIFF_W-1:0]   min_difficulty;
  logic [DIFF_W-1:0]   max_difficulty;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                cfg_write;

  // control state
  logic [2:0]          state;
  logic [SLOT_W-1:0]   write_slot;
  logic [SEEN_W-1:0]   blocks_seen;
  logic [SINCE_W-1:0]  since_retarget;
  logic [MCNT_W-1:0]   mcnt;

  // per item payload
  logic [TIME_BITS-1:0] ring [RING_DEPTH];
  logic [TIME_BITS-1:0] oldest;
  logic [TIME_BITS-1:0] now_r;
  logic [TIME_BITS-1:0] span;
  logic [DIFF_W-1:0]    cur_r;
  logic [SLOT_W-1:0]    win_r;
  logic [NUM_W-1:0]     num;
  logic [LO_W-1:0]      lo;
  logic [RATIO_W-1:0]   ratio;
  logic [PROD_W-1:0]    acc;
  logic [ROUND_W-1:0]   rnd;
  result_t              pend;

  // combinational
  logic                 accept;
  logic [TIME_BITS-1:0] now_c;
  logic [SLOT_W-1:0]    win_c;
  logic [SLOT_W-1:0]    old_slot_c;
  logic [SLOT_W-1:0]    write_slot_next;
  logic [SEEN_W-1:0]    blocks_seen_next;
  logic [SLOT_W-1:0]    since_inc;
  logic [SINCE_W-1:0]   since_retarget_next;
  logic                 first;
  logic                 due;
  logic [FACTOR_W-1:0]  mf_eff;
  logic [RATIO_W-1:0]   hi;
  logic [RATIO_W-1:0]   ratio_hi;
  logic [RATIO_W-1:0]   ratio_c;
  logic [DIFF_W-1:0]    sat_c;
  logic [DIFF_W-1:0]    bounded_c;
  logic                 div_start;
  logic                 div_done;
  logic [DVD_W-1:0]     div_dividend;
  logic [TIME_BITS-1:0] div_divisor;
  logic [DVD_W-1:0]     div_q;

  // ---------------- configuration port ----------------
  assign pready    = 1'b1;
  assign reg_idx   = paddr[ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_block_time <= TARGET_RST;
      window_size       <= WINDOW_RST;
      max_factor        <= MAX_FACTOR_RST;
      min_difficulty    <= MIN_DIFF_RST;
      max_difficulty    <= MAX_DIFF_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_TARGET:     target_block_time <= pwdata[TARGET_W-1:0];
        REG_WINDOW:     window_size       <= pwdata[WINREG_W-1:0];
        REG_MAX_FACTOR: max_factor        <= pwdata[FACTOR_W-1:0];
        REG_MIN_DIFF:   min_difficulty    <= pwdata[DIFF_W-1:0];
        REG_MAX_DIFF:   max_difficulty    <= pwdata[DIFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TARGET:     prdata = DATA_W'(target_block_time);
      REG_WINDOW:     prdata = DATA_W'(window_size);
      REG_MAX_FACTOR: prdata = DATA_W'(max_factor);
      REG_MIN_DIFF:   prdata = DATA_W'(min_difficulty);
      REG_MAX_DIFF:   prdata = DATA_W'(max_difficulty);
      default:        prdata = '0;
    endcase
  end

  // ---------------- window bookkeeping ----------------
  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign now_c      = TIME_BITS'(item.block_time);

  always_comb begin
    if (window_size == '0) begin
      win_c = SLOT_W'(1);
    end else if (int'(window_size) > WINDOW_MAX) begin
      win_c = SLOT_W'(WINDOW_MAX);
    end else begin
      win_c = SLOT_W'(window_size);
    end

    if (write_slot >= win_c) begin
      old_slot_c = write_slot - win_c;
    end else begin
      old_slot_c = SLOT_W'({1'b0, write_slot} + (SLOT_W + 1)'(RING_DEPTH) - {1'b0, win_c});
    end

    write_slot_next = (write_slot == SLOT_W'(RING_DEPTH - 1)) ? '0 : write_slot + 1'b1;
    first = (blocks_seen == '0);
    blocks_seen_next = (blocks_seen < SEEN_W'(RING_DEPTH)) ? blocks_seen + 1'b1 : blocks_seen;

    // a shrunk window makes the counter wrap on the next block
    since_inc = SLOT_W'(since_retarget) + 1'b1;
    if (first || since_inc >= win_c) begin
      since_retarget_next = '0;
    end else begin
      since_retarget_next = SINCE_W'(since_inc);
    end

    due = !first && (since_retarget_next == '0) &&
          ({1'b0, blocks_seen_next} >= ({1'b0, SEEN_W'(win_c)} + 1'b1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot     <= '0;
      blocks_seen    <= '0;
      since_retarget <= '0;
    end else if (accept) begin
      write_slot     <= write_slot_next;
      blocks_seen    <= blocks_seen_next;
      since_retarget <= since_retarget_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ring[write_slot] <= now_c;
      oldest           <= ring[old_slot_c];
    end
  end

  // ---------------- ratio and clamps ----------------
  assign mf_eff = (max_factor < FACTOR_ONE) ? FACTOR_ONE : max_factor;
  assign hi     = {mf_eff, 8'h00};

  always_comb begin
    ratio_hi = (div_q > DVD_W'(hi)) ? hi : RATIO_W'(div_q);
    ratio_c  = (ratio_hi < RATIO_W'(lo)) ? RATIO_W'(lo) : ratio_hi;

    sat_c     = (|rnd[ROUND_W-1:DIFF_W]) ? '1 : rnd[DIFF_W-1:0];
    bounded_c = (sat_c > max_difficulty) ? max_difficulty : sat_c;
    if (bounded_c < min_difficulty) begin
      bounded_c = min_difficulty;
    end
  end

  // first pass divides 2^24 by the factor, second pass is the ratio
  assign div_start    = ((state == S_CHECK) && (now_r > oldest)) ||
                        ((state == S_LO) && div_done);
  assign div_dividend = (state == S_CHECK) ? DVD_W'(LO_NUM) : {num, {FRAC_BITS{1'b0}}};
  assign div_divisor  = (state == S_CHECK) ? TIME_BITS'(mf_eff) : span;

  drt_div #(
    .DVD_W (DVD_W),
    .DVS_W (TIME_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      mcnt         <= '0;
    end else begin
      // a new result may load in the cycle the previous one leaves
      if ((state == S_DONE) && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= due ? S_CHECK : S_DONE;
          end
        end
        S_CHECK: begin
          state <= (now_r > oldest) ? S_LO : S_DONE;
        end
        S_LO: begin
          if (div_done) begin
            state <= S_RATIO;
          end
        end
        S_RATIO: begin
          if (div_done) begin
            state <= S_MUL;
            mcnt  <= MCNT_W'(RATIO_W);
          end
        end
        S_MUL: begin
          mcnt <= mcnt - 1'b1;
          if (mcnt == MCNT_W'(1)) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: state <= S_CLAMP;
        S_CLAMP: state <= S_DONE;
        S_DONE: begin
          if (!result_valid || result_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          now_r <= now_c;
          cur_r <= item.current_difficulty;
          win_r <= win_c;
          pend  <= '{next_difficulty: item.current_difficulty,
                     retargeted: 1'b0, span_invalid: 1'b0};
        end
      end
      S_CHECK: begin
        span <= now_r - oldest;
        num  <= NUM_W'(win_r) * NUM_W'(target_block_time);
        if (now_r <= oldest) begin
          pend.span_invalid <= 1'b1;
        end
      end
      S_LO: begin
        if (div_done) begin
          lo <= div_q[LO_W-1:0];
        end
      end
      S_RATIO: begin
        if (div_done) begin
          ratio <= ratio_c;
          acc   <= '0;
        end
      end
      S_MUL: begin
        // msb first shift and add
        acc   <= {acc[PROD_W-2:0], 1'b0} + (ratio[RATIO_W-1] ? PROD_W'(cur_r) : '0);
        ratio <= {ratio[RATIO_W-2:0], 1'b0};
      end
      S_ROUND: begin
        rnd <= ROUND_W'(({1'b0, acc} + (PROD_W + 1)'(ROUND_HALF)) >> FRAC_BITS);
      end
      S_CLAMP: begin
        pend.next_difficulty <= bounded_c;
        pend.retargeted      <= 1'b1;
      end
      S_DONE: begin
        if (!result_valid || result_ready) begin
          result <= pend;
        end
      end
      default: ;
    endcase
  end

  // ---------------- assertions ----------------
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.retargeted && result.span_invalid))
    else $error("retargeted and span_invalid both set");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("second transaction accepted while an item is in flight");

  a_seen_bound: assert property (@(posedge clk) disable iff (rst)
    blocks_seen <= SEEN_W'(RING_DEPTH))
    else $error("block count beyond ring depth");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_LO || state == S_RATIO))
    else $error("divider finished outside a divide phase");

  a_retarget_min: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.retargeted) |-> (result.next_difficulty >= min_difficulty))
    else $error("retargeted difficulty below lower bound");

endmodule
